// ===== rtl/lkrc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU keyed result cache package
// Beat types, entry type, cell control and opcode constants shared by the
// cache cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkrc_pkg;

    localparam int KEY_BITS     = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int REASON_BITS  = 8;
    localparam int COUNT_BITS   = 32;
    localparam int CAP_BITS     = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [2:0] OP_FIND          = 3'd0;
    localparam logic [2:0] OP_PEEK          = 3'd1;
    localparam logic [2:0] OP_STORE         = 3'd2;
    localparam logic [2:0] OP_STORE_FAILURE = 3'd3;
    localparam logic [2:0] OP_FORGET        = 3'd4;
    localparam logic [2:0] OP_CLEAR         = 3'd5;

    // What every cell does in a given cycle.
    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_CMP,
        ACT_FRONT,
        ACT_REMOVE,
        ACT_CLEAR
    } t_act;

    typedef struct packed {
        t_act act;
        logic evict;
    } t_cell_ctl;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key_high;
        logic [KEY_BITS-1:0]     key_low;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    failed;
        logic [REASON_BITS-1:0]  reason;
    } t_entry;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [KEY_BITS-1:0]     key_high;
        logic [KEY_BITS-1:0]     key_low;
        logic [PAYLOAD_BITS-1:0] payload_in;
        logic [REASON_BITS-1:0]  reason_in;
    } t_req;

    typedef struct packed {
        logic                    present;
        logic                    entry_failed;
        logic [PAYLOAD_BITS-1:0] payload_out;
        logic [REASON_BITS-1:0]  reason_out;
        logic [COUNT_BITS-1:0]   hit_count;
        logic [COUNT_BITS-1:0]   miss_count;
        logic [COUNT_BITS-1:0]   failure_hit_count;
        logic [COUNT_BITS-1:0]   insertion_count;
        logic [COUNT_BITS-1:0]   eviction_count;
    } t_rsp;

endpackage

// ===== rtl/lkrc_cell.sv =====
// ----------------------------------------------------------------------------
// LRU keyed result cache cell
// Holds one entry of the recency chain. Compares its key, and takes the entry
// of its upper or lower neighbor when the chain shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkrc_cell
    import lkrc_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [KEY_BITS-1:0] i_cmp_key_high,
    input  logic [KEY_BITS-1:0] i_cmp_key_low,
    input  logic [CW-1:0]       i_cap,
    input  logic                i_prev_valid,
    input  t_entry              i_prev_entry,
    input  logic                i_next_valid,
    input  t_entry              i_next_entry,
    input  logic                i_hit_before,
    output logic                o_valid,
    output t_entry              o_entry,
    output logic                o_match,
    output logic                o_hit_after
);

    logic   r_valid;
    logic   r_match;
    t_entry r_entry;
    logic   n_valid;
    logic   n_match;
    t_entry n_entry;

    always_comb begin
        n_valid = r_valid;
        n_match = r_match;
        n_entry = r_entry;
        case (i_ctl.act)
            ACT_CMP: begin
                n_match = r_valid && (r_entry.key_high == i_cmp_key_high)
                          && (r_entry.key_low == i_cmp_key_low);
            end
            ACT_FRONT: begin
                // Cells up to and including the hit take their upper neighbor.
                if (!i_hit_before) begin
                    n_valid = i_prev_valid && (!i_ctl.evict || (CW'(IDX) < i_cap));
                    n_entry = i_prev_entry;
                end
            end
            ACT_REMOVE: begin
                if (i_hit_before || r_match) begin
                    n_valid = i_next_valid;
                    n_entry = i_next_entry;
                end
            end
            ACT_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
        end
        r_entry <= n_entry;
    end

    assign o_valid     = r_valid;
    assign o_entry     = r_entry;
    assign o_match     = r_match;
    assign o_hit_after = i_hit_before | r_match;

endmodule

// ===== rtl/lru_keyed_result_cache.sv =====
// ----------------------------------------------------------------------------
// LRU keyed result cache
// Flow: a request beat is accepted only while idle, its key is compared against
// every cell, and then the chain is updated and the result registered.
// A new request is taken only once the last one is done; the update step waits
// while the result register is full and stalled.
// Reset: synchronous, clears all entries, the entry count and the statistics
// counters, and sets the capacity to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_keyed_result_cache
    import lkrc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_req                i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_rsp                o_out_beat,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_BITS-1:0] i_cfg_data
);

    // Entry count width and the width used to clamp the capacity register.
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CW > CAP_BITS) ? CW : CAP_BITS;

    // Request flow: the beat is captured in IDLE, every cell compares its key
    // against it in LOOK, and the chain is updated and the result registered
    // in APPLY.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_APPLY
    } t_state;

    t_state                r_state;
    t_req                  r_req;
    t_rsp                  r_rsp;
    logic                  r_out_valid;
    logic [CAP_BITS-1:0]   r_cap;
    logic [CW-1:0]         r_count;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic [COUNT_BITS-1:0] r_miss_cnt;
    logic [COUNT_BITS-1:0] r_fhit_cnt;
    logic [COUNT_BITS-1:0] r_ins_cnt;
    logic [COUNT_BITS-1:0] r_evict_cnt;

    t_rsp                  n_rsp;
    logic [CW-1:0]         n_count;
    logic [COUNT_BITS-1:0] n_hit_cnt;
    logic [COUNT_BITS-1:0] n_miss_cnt;
    logic [COUNT_BITS-1:0] n_fhit_cnt;
    logic [COUNT_BITS-1:0] n_ins_cnt;
    logic [COUNT_BITS-1:0] n_evict_cnt;

    // Cell chain wiring. Cell 0 is the most recent entry; valid cells always
    // form an unbroken run starting at cell 0.
    logic [MAX_ENTRIES-1:0] w_valid;
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES:0]   w_hb;
    t_entry                 w_entry [MAX_ENTRIES];

    t_cell_ctl        w_ctl;
    t_entry           w_front;
    t_entry           w_hit_entry;
    logic             w_hit;
    logic             w_advance;
    logic             w_accept;
    logic [CMP_W-1:0] w_cap_ext;
    logic [CW-1:0]    w_cap;
    logic [CW-1:0]    w_cap_m1;
    logic [CW-1:0]    w_keep;
    logic [CW-1:0]    w_evicted;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_rsp;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_advance = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);

    // The hit chain runs through the cells; its far end says whether any
    // cell matched.
    assign w_hb[0] = 1'b0;
    assign w_hit   = w_hb[MAX_ENTRIES];

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic   w_pv;
        t_entry w_pe;
        logic   w_nv;
        t_entry w_ne;

        if (g == 0) begin : g_head
            assign w_pv = 1'b1;
            assign w_pe = w_front;
        end else begin : g_body
            assign w_pv = w_valid[g-1];
            assign w_pe = w_entry[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_ne = w_front;
        end else begin : g_mid
            assign w_nv = w_valid[g+1];
            assign w_ne = w_entry[g+1];
        end

        lkrc_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_cmp_key_high (r_req.key_high),
            .i_cmp_key_low  (r_req.key_low),
            .i_cap          (w_cap),
            .i_prev_valid   (w_pv),
            .i_prev_entry   (w_pe),
            .i_next_valid   (w_nv),
            .i_next_entry   (w_ne),
            .i_hit_before   (w_hb[g]),
            .o_valid        (w_valid[g]),
            .o_entry        (w_entry[g]),
            .o_match        (w_match[g]),
            .o_hit_after    (w_hb[g+1])
        );
    end

    // Keys are unique, so at most one cell matches and an AND-OR select
    // picks out the hit entry.
    always_comb begin
        w_hit_entry = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_entry = w_hit_entry | w_entry[i];
            end
        end
    end

    // Effective capacity: zero behaves as one, and anything above the number
    // of cells behaves as the number of cells.
    always_comb begin
        w_cap_ext = CMP_W'(r_cap);
        if (w_cap_ext == '0) begin
            w_cap_ext = CMP_W'(1);
        end
        if (w_cap_ext > CMP_W'(MAX_ENTRIES)) begin
            w_cap_ext = CMP_W'(MAX_ENTRIES);
        end
        w_cap    = w_cap_ext[CW-1:0];
        w_cap_m1 = w_cap - CW'(1);
        // An insert first trims the chain down to one less than the capacity.
        if (r_count > w_cap_m1) begin
            w_keep    = w_cap_m1;
            w_evicted = r_count - w_cap_m1;
        end else begin
            w_keep    = r_count;
            w_evicted = '0;
        end
    end

    // The entry that lands in cell 0: the hit entry for a find, or the new
    // contents for a store of either kind.
    always_comb begin
        w_front          = w_hit_entry;
        w_front.key_high = r_req.key_high;
        w_front.key_low  = r_req.key_low;
        case (r_req.opcode)
            OP_STORE: begin
                w_front.payload = r_req.payload_in;
                w_front.failed  = 1'b0;
                w_front.reason  = '0;
            end
            OP_STORE_FAILURE: begin
                w_front.payload = '0;
                w_front.failed  = 1'b1;
                w_front.reason  = r_req.reason_in;
            end
            default: begin
            end
        endcase
    end

    // Chain command, counters and the result beat of the update cycle.
    always_comb begin
        w_ctl       = '{act: ACT_HOLD, evict: 1'b0};
        n_count     = r_count;
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_fhit_cnt  = r_fhit_cnt;
        n_ins_cnt   = r_ins_cnt;
        n_evict_cnt = r_evict_cnt;

        if (r_state == S_LOOK) begin
            w_ctl.act = ACT_CMP;
        end

        if (w_advance) begin
            case (r_req.opcode)
                OP_FIND: begin
                    if (w_hit) begin
                        w_ctl.act = ACT_FRONT;
                        n_hit_cnt = r_hit_cnt + 1'b1;
                        if (w_hit_entry.failed) begin
                            n_fhit_cnt = r_fhit_cnt + 1'b1;
                        end
                    end else begin
                        n_miss_cnt = r_miss_cnt + 1'b1;
                    end
                end
                OP_STORE, OP_STORE_FAILURE: begin
                    w_ctl.act = ACT_FRONT;
                    if (!w_hit) begin
                        // Insert: shift the whole chain, dropping the tail
                        // entries beyond the capacity.
                        w_ctl.evict = 1'b1;
                        n_count     = w_keep + CW'(1);
                        n_ins_cnt   = r_ins_cnt + 1'b1;
                        n_evict_cnt = r_evict_cnt
                                      + {{(COUNT_BITS - CW){1'b0}}, w_evicted};
                    end
                end
                OP_FORGET: begin
                    if (w_hit) begin
                        w_ctl.act = ACT_REMOVE;
                        n_count   = r_count - CW'(1);
                    end
                end
                OP_CLEAR: begin
                    w_ctl.act = ACT_CLEAR;
                    n_count   = '0;
                end
                default: begin
                end
            endcase
        end

        n_rsp                   = '0;
        n_rsp.present           = w_hit && ((r_req.opcode == OP_FIND)
                                  || (r_req.opcode == OP_PEEK)
                                  || (r_req.opcode == OP_FORGET));
        if (w_hit && ((r_req.opcode == OP_FIND) || (r_req.opcode == OP_PEEK))) begin
            n_rsp.entry_failed = w_hit_entry.failed;
            n_rsp.payload_out  = w_hit_entry.payload;
            n_rsp.reason_out   = w_hit_entry.reason;
        end
        n_rsp.hit_count         = n_hit_cnt;
        n_rsp.miss_count        = n_miss_cnt;
        n_rsp.failure_hit_count = n_fhit_cnt;
        n_rsp.insertion_count   = n_ins_cnt;
        n_rsp.eviction_count    = n_evict_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_fhit_cnt  <= '0;
            r_ins_cnt   <= '0;
            r_evict_cnt <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            r_count     <= n_count;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_fhit_cnt  <= n_fhit_cnt;
            r_ins_cnt   <= n_ins_cnt;
            r_evict_cnt <= n_evict_cnt;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_advance) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The result register frees up when its beat is taken and is
            // refilled by the update cycle.
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_req <= i_in_beat;
        end
        if (w_advance) begin
            r_rsp <= n_rsp;
        end
    end

    // The entry count always matches the run of valid cells at the head.
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_valid) == int'(r_count))
        && ((w_valid & (w_valid + 1'b1)) == '0))
        else $error("entry count and valid cells disagree");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above the number of cells");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(w_match))
        else $error("more than one cell matched the key");

    a_forget_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_hit && (r_req.opcode == OP_FORGET))
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("forget hit did not drop one entry");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_APPLY))
        else $error("result beat appeared outside the update cycle");

endmodule
